>>> rtl/assert_macros.svh
// Assertion macros for the top level, which checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, sampled on the rising clock edge outside reset.
`define RMVS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, sampled on the rising clock edge outside reset.
`define RMVS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

>>> rtl/rmvs_pkg.sv
// Package of the running statistics block: widths, limits, opcodes and control types.
package rmvs_pkg;
	localparam int COUNT_WIDTH_DEF  = 16;
	localparam int SAMPLE_WIDTH_DEF = 32;
	localparam int M2_W             = 64;
	localparam int VAR_W            = 63;
	localparam int SD_W             = 40;
	localparam int FRAC_W           = 16;
	localparam int STEP_W           = 7;
	localparam int SQ_REM_W         = 42;
	localparam int SQ_OP_W          = 2 * SD_W;

	localparam logic [M2_W-1:0] M2_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

	localparam logic OP_CLEAR = 1'b0;
	localparam logic OP_PUSH  = 1'b1;

	typedef struct packed {
		logic accept;
		logic step_div;
		logic step_mul;
		logic step_sq;
		logic mean_done;
		logic mul_done;
		logic var_done;
		logic sqrt_done;
		logic load_out;
	} rmvs_cmd_t;

	typedef struct packed {
		logic quick;
		logic unit_done;
	} rmvs_stat_t;
endpackage

>>> rtl/rmvs_dp.sv
// Datapath: statistics registers, shared serial divider, serial multiplier, square root, result.
module rmvs_dp import rmvs_pkg::*; #(
	parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rmvs_cmd_t                      cmd,
	output rmvs_stat_t                     stat,
	input  logic                           op,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	output logic        [COUNT_WIDTH-1:0]  sample_total,
	output logic signed [SAMPLE_WIDTH-1:0] minimum,
	output logic signed [SAMPLE_WIDTH-1:0] maximum,
	output logic signed [SAMPLE_WIDTH-1:0] mean,
	output logic        [VAR_W-1:0]        variance,
	output logic        [SD_W-1:0]         std_dev,
	output logic                           full_res
);
	localparam int DW  = SAMPLE_WIDTH + 1;
	localparam int PW  = 2 * DW;
	localparam int PWX = (PW > M2_W) ? PW : M2_W + 1;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
	localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
	localparam logic [STEP_W-1:0] MEAN_STEPS = STEP_W'(DW);
	localparam logic [STEP_W-1:0] VAR_STEPS  = STEP_W'(VAR_W);
	localparam logic [STEP_W-1:0] SQ_STEPS   = STEP_W'(SD_W);

	logic        [COUNT_WIDTH-1:0]  count_q;
	logic signed [SAMPLE_WIDTH-1:0] min_q;
	logic signed [SAMPLE_WIDTH-1:0] max_q;
	logic signed [SAMPLE_WIDTH-1:0] mean_q;
	logic        [M2_W-1:0]         m2_q;
	logic        [VAR_W-1:0]        var_q;
	logic        [SD_W-1:0]         sd_q;
	logic                           full_q;
	logic signed [SAMPLE_WIDTH-1:0] x_q;
	logic        [STEP_W-1:0]       step_q;

	logic [COUNT_WIDTH-1:0] div_rem_q;
	logic [M2_W-1:0]        div_quo_q;
	logic [COUNT_WIDTH-1:0] div_dvs_q;
	logic [PW-1:0]          acc_q;
	logic [PW-1:0]          mc_q;
	logic [DW-1:0]          mp_q;
	logic [SQ_OP_W-1:0]     sq_op_q;
	logic [SQ_REM_W-1:0]    sq_rem_q;
	logic [SD_W-1:0]        sq_root_q;

	logic        [COUNT_WIDTH-1:0]  total_q;
	logic signed [SAMPLE_WIDTH-1:0] omin_q;
	logic signed [SAMPLE_WIDTH-1:0] omax_q;
	logic signed [SAMPLE_WIDTH-1:0] omean_q;
	logic        [VAR_W-1:0]        ovar_q;
	logic        [SD_W-1:0]         osd_q;
	logic                           ofull_q;

	logic                           full_now;
	logic        [COUNT_WIDTH-1:0]  count_n;
	logic signed [DW-1:0]           din;
	logic        [DW-1:0]           din_mag;
	logic signed [DW-1:0]           delta;
	logic        [DW-1:0]           delta_mag;
	logic        [DW-1:0]           qmag;
	logic signed [DW-1:0]           mean_sum;
	logic signed [SAMPLE_WIDTH-1:0] mean_new;
	logic signed [DW-1:0]           dev;
	logic        [DW-1:0]           dev_mag;
	logic        [COUNT_WIDTH:0]    div_t;
	logic        [COUNT_WIDTH:0]    div_sub;
	logic                           div_ge;
	logic        [PWX-1:0]          acc_x;
	logic                           prod_ovf;
	logic        [M2_W-1:0]         prod;
	logic        [M2_W:0]           m2_sum;
	logic        [M2_W-1:0]         m2_new;
	logic        [SQ_REM_W+1:0]     sq_t;
	logic        [SQ_REM_W+1:0]     sq_trial;
	logic        [SQ_REM_W+1:0]     sq_diff;
	logic                           sq_ge;

	always_comb begin
		full_now  = count_q == COUNT_MAX;
		count_n   = count_q + 1'b1;
		din       = {sample[SAMPLE_WIDTH-1], sample} - {mean_q[SAMPLE_WIDTH-1], mean_q};
		din_mag   = din[DW-1] ? DW'(-din) : DW'(din);
		delta     = {x_q[SAMPLE_WIDTH-1], x_q} - {mean_q[SAMPLE_WIDTH-1], mean_q};
		delta_mag = delta[DW-1] ? DW'(-delta) : DW'(delta);
		qmag      = div_quo_q[DW-1:0];
		mean_sum  = {mean_q[SAMPLE_WIDTH-1], mean_q} + (delta[DW-1] ? -qmag : qmag);
		mean_new  = mean_sum[SAMPLE_WIDTH-1:0];
		dev       = {x_q[SAMPLE_WIDTH-1], x_q} - {mean_new[SAMPLE_WIDTH-1], mean_new};
		dev_mag   = dev[DW-1] ? DW'(-dev) : DW'(dev);

		div_t   = {div_rem_q, div_quo_q[M2_W-1]};
		div_sub = div_t - {1'b0, div_dvs_q};
		div_ge  = div_t >= {1'b0, div_dvs_q};

		acc_x    = PWX'(acc_q);
		prod_ovf = |acc_x[PWX-1:M2_W];
		prod     = prod_ovf ? M2_LIMIT : (acc_x[M2_W-1:0] >> FRAC_W);
		m2_sum   = {1'b0, m2_q} + {1'b0, prod};
		m2_new   = (m2_sum > {1'b0, M2_LIMIT}) ? M2_LIMIT : m2_sum[M2_W-1:0];

		sq_t     = {sq_rem_q, sq_op_q[SQ_OP_W-1 -: 2]};
		sq_trial = {1'b0, sq_root_q, 2'b01};
		sq_diff  = sq_t - sq_trial;
		sq_ge    = sq_t >= sq_trial;

		stat.quick     = (op == OP_CLEAR) || full_now || (count_q == '0);
		stat.unit_done = step_q == '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			min_q   <= SMP_MAX;
			max_q   <= SMP_MIN;
			mean_q  <= '0;
			m2_q    <= '0;
			var_q   <= '0;
			sd_q    <= '0;
			full_q  <= 1'b0;
			step_q  <= '0;
		end else begin
			if (cmd.step_div || cmd.step_mul || cmd.step_sq) begin
				step_q <= step_q - 1'b1;
			end
			if (cmd.accept) begin
				priority if (op == OP_CLEAR) begin
					full_q  <= 1'b0;
					count_q <= '0;
					min_q   <= SMP_MAX;
					max_q   <= SMP_MIN;
					mean_q  <= '0;
					m2_q    <= '0;
					var_q   <= '0;
					sd_q    <= '0;
				end else if (full_now) begin
					full_q <= 1'b1;
				end else begin
					full_q  <= 1'b0;
					count_q <= count_n;
					if (sample < min_q) begin
						min_q <= sample;
					end
					if (sample > max_q) begin
						max_q <= sample;
					end
					if (count_q == '0) begin
						mean_q <= sample;
						m2_q   <= '0;
						var_q  <= '0;
						sd_q   <= '0;
					end else begin
						step_q <= MEAN_STEPS;
					end
				end
			end
			if (cmd.mean_done) begin
				mean_q <= mean_new;
				step_q <= MEAN_STEPS;
			end
			if (cmd.mul_done) begin
				m2_q   <= m2_new;
				step_q <= VAR_STEPS;
			end
			if (cmd.var_done) begin
				var_q  <= div_quo_q[VAR_W-1:0];
				step_q <= SQ_STEPS;
			end
			if (cmd.sqrt_done) begin
				sd_q <= sq_root_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x_q       <= sample;
			div_rem_q <= '0;
			div_quo_q <= M2_W'(din_mag) << (M2_W - DW);
			div_dvs_q <= count_n;
		end
		if (cmd.step_div) begin
			div_rem_q <= div_ge ? div_sub[COUNT_WIDTH-1:0] : div_t[COUNT_WIDTH-1:0];
			div_quo_q <= {div_quo_q[M2_W-2:0], div_ge};
		end
		if (cmd.mean_done) begin
			acc_q <= '0;
			mc_q  <= PW'(delta_mag);
			mp_q  <= dev_mag;
		end
		if (cmd.step_mul) begin
			if (mp_q[0]) begin
				acc_q <= acc_q + mc_q;
			end
			mc_q <= {mc_q[PW-2:0], 1'b0};
			mp_q <= {1'b0, mp_q[DW-1:1]};
		end
		if (cmd.mul_done) begin
			div_rem_q <= '0;
			div_quo_q <= {m2_new[M2_W-2:0], 1'b0};
			div_dvs_q <= count_q - 1'b1;
		end
		if (cmd.var_done) begin
			sq_op_q   <= {1'b0, div_quo_q[VAR_W-1:0], {FRAC_W{1'b0}}};
			sq_rem_q  <= '0;
			sq_root_q <= '0;
		end
		if (cmd.step_sq) begin
			sq_op_q   <= {sq_op_q[SQ_OP_W-3:0], 2'b00};
			sq_rem_q  <= sq_ge ? sq_diff[SQ_REM_W-1:0] : sq_t[SQ_REM_W-1:0];
			sq_root_q <= {sq_root_q[SD_W-2:0], sq_ge};
		end
		if (cmd.load_out) begin
			total_q <= count_q;
			omin_q  <= (count_q == '0) ? '0 : min_q;
			omax_q  <= (count_q == '0) ? '0 : max_q;
			omean_q <= (count_q == '0) ? '0 : mean_q;
			ovar_q  <= var_q;
			osd_q   <= sd_q;
			ofull_q <= full_q;
		end
	end

	assign sample_total = total_q;
	assign minimum      = omin_q;
	assign maximum      = omax_q;
	assign mean         = omean_q;
	assign variance     = ovar_q;
	assign std_dev      = osd_q;
	assign full_res     = ofull_q;
endmodule

>>> rtl/rmvs_ctrl.sv
// Controller: sequences the update of one item and owns both channel handshakes.
module rmvs_ctrl import rmvs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  rmvs_stat_t stat,
	output rmvs_cmd_t  cmd
);
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_DIVM = 6'b000010,
		S_MUL  = 6'b000100,
		S_DIVV = 6'b001000,
		S_SQRT = 6'b010000,
		S_DONE = 6'b100000
	} rmvs_state_t;

	rmvs_state_t state_q;
	rmvs_state_t state_d;
	logic        out_valid_q;

	always_comb begin
		cmd           = '0;
		state_d       = state_q;
		cmd.accept    = (state_q == S_IDLE) && in_valid;
		cmd.step_div  = ((state_q == S_DIVM) || (state_q == S_DIVV)) && !stat.unit_done;
		cmd.step_mul  = (state_q == S_MUL) && !stat.unit_done;
		cmd.step_sq   = (state_q == S_SQRT) && !stat.unit_done;
		cmd.mean_done = (state_q == S_DIVM) && stat.unit_done;
		cmd.mul_done  = (state_q == S_MUL) && stat.unit_done;
		cmd.var_done  = (state_q == S_DIVV) && stat.unit_done;
		cmd.sqrt_done = (state_q == S_SQRT) && stat.unit_done;
		cmd.load_out  = (state_q == S_DONE) && (!out_valid_q || !out_stall);
		unique case (state_q)
			S_IDLE: begin
				if (cmd.accept) begin
					state_d = stat.quick ? S_DONE : S_DIVM;
				end
			end
			S_DIVM: begin
				if (cmd.mean_done) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				if (cmd.mul_done) begin
					state_d = S_DIVV;
				end
			end
			S_DIVV: begin
				if (cmd.var_done) begin
					state_d = S_SQRT;
				end
			end
			S_SQRT: begin
				if (cmd.sqrt_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (cmd.load_out) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;
endmodule

>>> rtl/running_mean_variance_stats_core.sv
// Top level of the running statistics block: controller, datapath and checks.
// Usage:
// Input beats carry op (clear or push) and a signed Q16.16 sample; each accepted beat gives
// exactly one output beat with the count, minimum, maximum, mean, variance, standard
// deviation and a flag for a push ignored because the count is saturated.
// Both channels handshake with valid and stall; a beat moves when valid is high and stall low.
// One item is worked on at a time. A clear, an ignored push or the first sample after a
// clear goes from acceptance straight to the done state and is loaded into the output
// register there once that register is free. Any other push runs a serial divide for the
// mean, a serial multiply for the squared deviation, a 63-step divide for the variance and
// a 40-step square root, each unit working one bit per cycle, before the done state loads
// the result. The next input beat is taken once the controller is back in idle after that
// load; no new item is taken while one is in work.
// The next input beat is taken as soon as a result sits in the output register, even while
// the receiver stalls it; a further result then waits until that register is free.
// Reset clears the statistics to the cleared state and empties the output register.
module running_mean_variance_stats_core import rmvs_pkg::*; #(
	parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           op,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic        [COUNT_WIDTH-1:0]  sample_total,
	output logic signed [SAMPLE_WIDTH-1:0] minimum,
	output logic signed [SAMPLE_WIDTH-1:0] maximum,
	output logic signed [SAMPLE_WIDTH-1:0] mean,
	output logic        [VAR_W-1:0]        variance,
	output logic        [SD_W-1:0]         std_dev,
	output logic                           full_res
);
	rmvs_cmd_t  cmd;
	rmvs_stat_t stat;

	rmvs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	rmvs_dp #(
		.COUNT_WIDTH  (COUNT_WIDTH),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.op           (op),
		.sample       (sample),
		.sample_total (sample_total),
		.minimum      (minimum),
		.maximum      (maximum),
		.mean         (mean),
		.variance     (variance),
		.std_dev      (std_dev),
		.full_res     (full_res)
	);

`include "assert_macros.svh"

	`RMVS_ASSERT_IMP(a_full_count, out_valid && full_res, sample_total == '1,
		"full flag without saturated count")
	`RMVS_ASSERT_IMP(a_var_low, out_valid && (sample_total < COUNT_WIDTH'(2)),
		(variance == '0) && (std_dev == '0), "spread reported below two samples")
	`RMVS_ASSERT_IMP(a_min_max, out_valid && (sample_total != '0), minimum <= maximum,
		"minimum above maximum")
	`RMVS_ASSERT_NXT(a_load_free, cmd.load_out, out_valid && !in_stall,
		"result load did not free the input")
endmodule
